@@ hdl/ssfr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sync-stuffed frame receiver.
// Used by every module of the block; no dependencies.
package ssfr_pkg;

   localparam int BYTE_W          = 8;
   localparam int POS_W           = 9;
   localparam int ADDR_W          = 5;
   localparam int KIND_W          = 3;
   localparam int HDR_BYTES       = 4;
   localparam int FRAME_OVERHEAD  = 6;
   localparam int MAX_FRAME_BYTES_DEF = 258;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h1b;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD    = 3'd0,
      KIND_GOOD       = 3'd1,
      KIND_BAD        = 3'd2,
      KIND_SYNC_ROUTE = 3'd3,
      KIND_TOO_LONG   = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      logic [BYTE_W-1:0]   index;
      logic [BYTE_W-1:0]   route;
      logic [BYTE_W-1:0]   control;
      logic [BYTE_W-1:0]   length;
   } event_type;

endpackage

@@ hdl/sync_stuffed_frame_receiver.sv @@
`timescale 1ns / 1ps
// Top level of the sync-stuffed frame receiver: parser, event queue, output stage.
// Instantiates ssfr_front, ssfr_queue and ssfr_back; uses ssfr_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_rx_byte
//   rsp      out        rsp_valid / rsp_ready  rsp_event_kind .. rsp_payload_length
//   csr      in         csr_valid / csr_ready  csr_sync_byte
//
// One byte per cycle while the queue is not full; the parser state update and checksum add finish in that cycle.
// A result is registered first in the queue, then in the output register.
// Reset clears the parser and queue and loads the sync byte 0x1b.
// A stalled rsp fills the queue; req_ready drops only while the queue is full.
module sync_stuffed_frame_receiver
   import ssfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_event_kind,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [BYTE_W-1:0] rsp_payload_index,
   output logic [BYTE_W-1:0] rsp_route_byte,
   output logic [ADDR_W-1:0] rsp_node_address,
   output logic [BYTE_W-1:0] rsp_control_byte,
   output logic [BYTE_W-1:0] rsp_payload_length,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BYTE_W-1:0] csr_sync_byte
);

   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   logic      ev_push;
   event_type ev;
   event_type q_head;
   logic      byte_fire;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign byte_fire = req_valid && req_ready;

   ssfr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_sync_byte(csr_sync_byte),
      .byte_fire    (byte_fire),
      .rx_byte      (req_rx_byte),
      .ev_push      (ev_push),
      .ev           (ev)
   );

   ssfr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (ev_push),
      .push_data(ev),
      .pop      (q_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head     (q_head)
   );

   ssfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_route_byte    (rsp_route_byte),
      .rsp_node_address  (rsp_node_address),
      .rsp_control_byte  (rsp_control_byte),
      .rsp_payload_length(rsp_payload_length)
   );

endmodule

@@ hdl/ssfr_front.sv @@
`timescale 1ns / 1ps
// Front end: sync register, frame parser, destuffing and running checksum.
// Classifies each byte into at most one event for the queue; uses ssfr_pkg.
module ssfr_front
   import ssfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [BYTE_W-1:0] csr_sync_byte,
   input  logic              byte_fire,
   input  logic [BYTE_W-1:0] rx_byte,
   output logic              ev_push,
   output event_type         ev
);

   localparam logic [POS_W-1:0] MAX_TOTAL = POS_W'(MAX_FRAME_BYTES);

   logic [BYTE_W-1:0] sync_ff, sync_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              esc_ff, esc_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] route_ff, route_in;
   logic [BYTE_W-1:0] ctrl_ff, ctrl_in;
   logic [BYTE_W-1:0] len_ff, len_in;

   always_comb begin
      logic              take;
      logic              abort;
      logic [BYTE_W-1:0] len_eff;
      logic [POS_W-1:0]  pay_end;
      logic [POS_W-1:0]  pos_next;
      sync_in  = csr_valid ? csr_sync_byte : sync_ff;
      pos_in   = pos_ff;
      esc_in   = esc_ff;
      total_in = total_ff;
      sum_in   = sum_ff;
      route_in = route_ff;
      ctrl_in  = ctrl_ff;
      len_in   = len_ff;
      ev_push  = 1'b0;
      ev       = '0;
      take     = 1'b0;
      abort    = 1'b0;
      len_eff  = len_ff;
      pay_end  = '0;
      pos_next = '0;
      if (byte_fire) begin
         if (pos_ff == '0) begin
            take = (rx_byte == sync_ff);
         end else if (pos_ff == POS_W'(1)) begin
            if (rx_byte == sync_ff) begin
               pos_in   = '0;
               ev_push  = 1'b1;
               ev.kind  = KIND_SYNC_ROUTE;
            end else begin
               take = 1'b1;
            end
         end else if (rx_byte == sync_ff && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            take = 1'b1;
         end

         if (take) begin
            esc_in = 1'b0;
            if (pos_ff == POS_W'(3)) begin
               total_in = {1'b0, rx_byte} + POS_W'(FRAME_OVERHEAD);
               if (total_in > MAX_TOTAL) begin
                  abort      = 1'b1;
                  pos_in     = '0;
                  ev_push    = 1'b1;
                  ev.kind    = KIND_TOO_LONG;
                  ev.route   = route_ff;
                  ev.control = ctrl_ff;
                  ev.length  = rx_byte;
               end else begin
                  len_in  = rx_byte;
                  len_eff = rx_byte;
               end
            end
            if (!abort) begin
               pay_end = {1'b0, len_eff} + POS_W'(HDR_BYTES);
               if (pos_ff == '0) begin
                  sum_in = '0;
               end else if (pos_ff <= pay_end) begin
                  sum_in = sum_ff + rx_byte;
               end
               if (pos_ff == POS_W'(1)) begin
                  route_in = rx_byte;
               end else if (pos_ff == POS_W'(2)) begin
                  ctrl_in = rx_byte;
               end
               if (pos_ff >= POS_W'(HDR_BYTES) && pos_ff < pay_end) begin
                  ev_push  = 1'b1;
                  ev.kind  = KIND_PAYLOAD;
                  ev.data  = rx_byte;
                  ev.index = BYTE_W'(pos_ff - POS_W'(HDR_BYTES));
               end
               pos_next = pos_ff + POS_W'(1);
               if (pos_next == total_in) begin
                  pos_in     = '0;
                  ev_push    = 1'b1;
                  ev.kind    = (sum_in == '0) ? KIND_GOOD : KIND_BAD;
                  ev.data    = '0;
                  ev.index   = '0;
                  ev.route   = route_ff;
                  ev.control = ctrl_ff;
                  ev.length  = len_eff;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff  <= SYNC_RESET;
         pos_ff   <= '0;
         esc_ff   <= 1'b0;
         total_ff <= '0;
         sum_ff   <= '0;
         route_ff <= '0;
         ctrl_ff  <= '0;
         len_ff   <= '0;
      end else begin
         sync_ff  <= sync_in;
         pos_ff   <= pos_in;
         esc_ff   <= esc_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         route_ff <= route_in;
         ctrl_ff  <= ctrl_in;
         len_ff   <= len_in;
      end
   end

endmodule

@@ hdl/ssfr_queue.sv @@
`timescale 1ns / 1ps
// Short event queue between the parser and the output stage.
// Register-based FIFO of event_type entries; uses ssfr_pkg.
module ssfr_queue
   import ssfr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output event_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   event_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/ssfr_back.sv @@
`timescale 1ns / 1ps
// Back end: formats queued events into the result register.
// Zeroes fields that do not apply to the event; uses ssfr_pkg.
module ssfr_back
   import ssfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  event_type         q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_event_kind,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [BYTE_W-1:0] rsp_payload_index,
   output logic [BYTE_W-1:0] rsp_route_byte,
   output logic [ADDR_W-1:0] rsp_node_address,
   output logic [BYTE_W-1:0] rsp_control_byte,
   output logic [BYTE_W-1:0] rsp_payload_length
);

   logic              valid_ff;
   kind_type          kind_ff;
   logic [BYTE_W-1:0] data_ff, index_ff, route_ff, ctrl_ff, len_ff;
   logic [BYTE_W-1:0] data_in, index_in, route_in, ctrl_in, len_in;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      data_in  = '0;
      index_in = '0;
      route_in = '0;
      ctrl_in  = '0;
      len_in   = '0;
      case (q_head.kind)
         KIND_PAYLOAD: begin
            data_in  = q_head.data;
            index_in = q_head.index;
         end
         KIND_GOOD, KIND_BAD, KIND_TOO_LONG: begin
            route_in = q_head.route;
            ctrl_in  = q_head.control;
            len_in   = q_head.length;
         end
         default: begin
            data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff  <= q_head.kind;
         data_ff  <= data_in;
         index_ff <= index_in;
         route_ff <= route_in;
         ctrl_ff  <= ctrl_in;
         len_ff   <= len_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_payload_byte   = data_ff;
   assign rsp_payload_index  = index_ff;
   assign rsp_route_byte     = route_ff;
   assign rsp_node_address   = route_ff[ADDR_W-1:0];
   assign rsp_control_byte   = ctrl_ff;
   assign rsp_payload_length = len_ff;

endmodule
